>>> rtl/core/tsa_pkg.sv
// Shared types and constants for the tracked target slot assigner.
package tsa_pkg;

   // Fixed field widths of the ports and of the per-user state.
   localparam int MASK_W     = 6;
   localparam int SLOT_W     = 3;
   localparam int CNT_W      = 3;
   localparam int USER_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;

   // Default sizes of the design.
   localparam int DEF_MAX_USERS  = 4;
   localparam int DEF_SLOT_COUNT = 6;

   // Register reset values.
   localparam logic [CSR_DATA_W-1:0] RESET_USERS_IN_USE = 3'd2;
   localparam logic [CSR_DATA_W-1:0] RESET_HOLD_LIMIT   = 3'd5;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_USERS_IN_USE = 1'b0,
      CSR_HOLD_LIMIT   = 1'b1
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_EMIT
   } state_type;

   // Token that walks the row of user cells with the slot mask.
   typedef struct packed {
      logic valid;
      logic second;
   } link_type;

endpackage

>>> rtl/core/tsa_cell.sv
// One user cell: holds a user's slot and hold counter and updates the walking slot mask.
module tsa_cell #(
   parameter int SLOT_COUNT = tsa_pkg::DEF_SLOT_COUNT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_use,
   input  logic [tsa_pkg::CNT_W-1:0] lim,
   input  tsa_pkg::link_type         link_in,
   input  logic [SLOT_COUNT-1:0]     avail_in,
   output tsa_pkg::link_type         link_out,
   output logic [SLOT_COUNT-1:0]     avail_out,
   output logic [tsa_pkg::SLOT_W-1:0] slot,
   output logic [tsa_pkg::CNT_W-1:0]  count
);
   import tsa_pkg::*;

   link_type              link_ff, link_in_nx;
   logic [SLOT_COUNT-1:0] avail_ff, avail_in_nx;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SLOT_COUNT-1:0] held_bit;
   logic [SLOT_COUNT-1:0] low_bit;
   logic [SLOT_W-1:0]     low_idx;
   logic [CNT_W:0]        cnt_inc;

   // One-hot of the held slot; slots beyond the count never match.
   always_comb begin
      for (int j = 0; j < SLOT_COUNT; j++) begin
         held_bit[j] = (slot_ff == SLOT_W'(j));
      end
   end

   // Lowest available slot, as a one-hot and as an index.
   always_comb begin
      low_bit = avail_in & (~avail_in + 1'b1);
      low_idx = '0;
      for (int j = SLOT_COUNT - 1; j >= 0; j--) begin
         if (avail_in[j]) begin
            low_idx = SLOT_W'(j);
         end
      end
   end

   assign cnt_inc = {1'b0, cnt_ff} + 1'b1;

   // The first walk renews or ages the hold; the second hands out a free slot.
   always_comb begin
      link_in_nx  = link_in;
      avail_in_nx = avail_in;
      slot_in     = slot_ff;
      cnt_in      = cnt_ff;
      if (link_in.valid && in_use) begin
         if (!link_in.second) begin
            if (cnt_ff != '0) begin
               if ((avail_in & held_bit) != '0) begin
                  avail_in_nx = avail_in & ~held_bit;
                  cnt_in      = (cnt_inc > {1'b0, lim}) ? lim : cnt_inc[CNT_W-1:0];
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end else begin
            if (cnt_ff == '0 && avail_in != '0) begin
               slot_in     = low_idx;
               cnt_in      = CNT_W'(1);
               avail_in_nx = avail_in & ~low_bit;
            end
         end
      end
   end

   // State and the link register towards the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
         slot_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         link_ff <= link_in_nx;
         slot_ff <= slot_in;
         cnt_ff  <= cnt_in;
      end
      avail_ff <= avail_in_nx;
   end

   assign link_out  = link_ff;
   assign avail_out = avail_ff;
   assign slot      = slot_ff;
   assign count     = cnt_ff;

endmodule

>>> rtl/core/tracked_target_slot_assigner.sv
// Top level of the tracked target slot assigner: sequencer, user cell row and result register.
// For each item the slot mask walks the row of user cells twice, one cell a cycle (once to
// renew held slots, once to hand out free ones), and then one result per user in use leaves
// the result register, a cycle each unless stalled.
// The next item is taken while the last result still waits in the result register.
module tracked_target_slot_assigner #(
   parameter int MAX_USERS  = tsa_pkg::DEF_MAX_USERS,
   parameter int SLOT_COUNT = tsa_pkg::DEF_SLOT_COUNT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tsa_pkg::MASK_W-1:0]     req_tracked_mask,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tsa_pkg::USER_W-1:0]     rsp_user_index,
   output logic [tsa_pkg::SLOT_W-1:0]     rsp_slot_id,
   output logic [tsa_pkg::CNT_W-1:0]      rsp_hold_count,
   output logic [tsa_pkg::SLOT_W-1:0]     rsp_track_id,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tsa_pkg::CSR_DATA_W-1:0] csr_data
);
   import tsa_pkg::*;

   localparam int IW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
   localparam int NW = $clog2(MAX_USERS + 1);

   state_type             state_ff, state_in;
   logic [CSR_DATA_W-1:0] users_ff, limit_ff;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [SLOT_COUNT-1:0] tracked_ff, tracked_in;
   logic [SLOT_COUNT-1:0] req_mask;
   logic [NW-1:0]         n_eff;
   logic [CNT_W-1:0]      lim_eff;
   logic [MAX_USERS-1:0]  in_use;

   link_type              link_chain  [MAX_USERS+1];
   logic [SLOT_COUNT-1:0] avail_chain [MAX_USERS+1];
   logic [SLOT_W-1:0]     cell_slot   [MAX_USERS];
   logic [CNT_W-1:0]      cell_cnt    [MAX_USERS];
   link_type              link_start;
   logic [SLOT_COUNT-1:0] avail_start;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [USER_W-1:0]     rsp_user_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_track_ff;
   logic [CNT_W-1:0]      rsp_cnt_ff;
   logic                  rsp_last_ff;
   logic                  load;
   logic                  is_last;
   logic [SLOT_W-1:0]     sel_slot;
   logic [CNT_W-1:0]      sel_cnt;
   logic                  sel_on;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         users_ff <= RESET_USERS_IN_USE;
         limit_ff <= RESET_HOLD_LIMIT;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_USERS_IN_USE: users_ff <= csr_data;
            CSR_HOLD_LIMIT:   limit_ff <= csr_data;
            default:          ;
         endcase
      end
   end

   // Effective user count and hold limit after clamping.
   always_comb begin
      if (users_ff == '0) begin
         n_eff = NW'(1);
      end else if (int'(users_ff) > MAX_USERS) begin
         n_eff = NW'(MAX_USERS);
      end else begin
         n_eff = NW'(users_ff);
      end
      lim_eff = (limit_ff == '0) ? CNT_W'(1) : limit_ff;
   end

   // Mask bits at or above the slot count are dropped.
   for (genvar j = 0; j < SLOT_COUNT; j++) begin : g_mask
      if (j < MASK_W) begin : g_in
         assign req_mask[j] = req_tracked_mask[j];
      end else begin : g_out
         assign req_mask[j] = 1'b0;
      end
   end

   // The sequencer feeds the first cell of the row.
   assign link_chain[0]  = link_start;
   assign avail_chain[0] = avail_start;

   // Row of user cells; the mask and token move one cell a cycle.
   for (genvar i = 0; i < MAX_USERS; i++) begin : g_cell
      assign in_use[i] = (NW'(i) < n_eff);
      tsa_cell #(
         .SLOT_COUNT(SLOT_COUNT)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_use    (in_use[i]),
         .lim       (lim_eff),
         .link_in   (link_chain[i]),
         .avail_in  (avail_chain[i]),
         .link_out  (link_chain[i+1]),
         .avail_out (avail_chain[i+1]),
         .slot      (cell_slot[i]),
         .count     (cell_cnt[i])
      );
   end

   // Result fields of the user being emitted.
   always_comb begin
      sel_cnt  = cell_cnt[idx_ff];
      sel_slot = (sel_cnt != '0) ? cell_slot[idx_ff] : '0;
      sel_on   = 1'b0;
      for (int j = 0; j < SLOT_COUNT; j++) begin
         if (sel_slot == SLOT_W'(j) && tracked_ff[j]) begin
            sel_on = 1'b1;
         end
      end
      sel_on  = sel_on && (sel_cnt != '0);
      is_last = ((NW'(idx_ff) + 1'b1) == n_eff);
   end

   // Sequencer: start the first walk, chain the second, then emit results.
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      tracked_in  = tracked_ff;
      link_start  = '0;
      avail_start = avail_chain[MAX_USERS];
      load        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               link_start.valid = 1'b1;
               avail_start      = req_mask;
               tracked_in       = req_mask;
               state_in         = ST_WALK;
            end
         end
         ST_WALK: begin
            if (link_chain[MAX_USERS].valid) begin
               if (!link_chain[MAX_USERS].second) begin
                  link_start.valid  = 1'b1;
                  link_start.second = 1'b1;
               end else begin
                  idx_in   = '0;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load   = 1'b1;
               idx_in = idx_ff + 1'b1;
               if (is_last) begin
                  idx_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tracked_ff <= tracked_in;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_user_ff  <= USER_W'(idx_ff);
         rsp_slot_ff  <= sel_slot;
         rsp_cnt_ff   <= sel_cnt;
         rsp_track_ff <= sel_on ? (sel_slot + 1'b1) : '0;
         rsp_last_ff  <= is_last;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_user_index = rsp_user_ff;
   assign rsp_slot_id    = rsp_slot_ff;
   assign rsp_hold_count = rsp_cnt_ff;
   assign rsp_track_id   = rsp_track_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef NO_ASSERTIONS
   logic [MAX_USERS-1:0] tok_vec;

   for (genvar i = 0; i < MAX_USERS; i++) begin : g_tok
      assign tok_vec[i] = link_chain[i].valid;
   end

   // Only one token is ever inside the row of cells.
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one token inside the cell row");

   // A tracked id is only reported for a user that holds a slot.
   a_track_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_track_id != '0) |-> (rsp_hold_count != '0))
      else $error("track id given for a user without a slot");

   // Once an item is taken, no further item is taken in the next cycle.
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after an item was taken");
`endif

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Testbench for the tracked target slot assigner: frame scoreboard, item drivers and result checks.
module tb;
   import tsa_pkg::*;

   localparam int USERS_MAX     = DEF_MAX_USERS;
   localparam int SLOTS         = DEF_SLOT_COUNT;
   // Two walks of the user row, the results and a margin.
   localparam int SETTLE_CYCLES = 3 * USERS_MAX + 1 + 8;
   localparam int HOLD_OFF_LEN  = 300;

   // One user result as it leaves the block.
   typedef struct packed {
      logic [USER_W-1:0] user_index;
      logic [SLOT_W-1:0] slot_id;
      logic [CNT_W-1:0]  hold_count;
      logic [SLOT_W-1:0] track_id;
      logic              last;
   } slot_result_type;

   // Keeps its own copy of the per-user slot state and the expected user results.
   class slot_board_type;
      int users_cfg;
      int limit_cfg;
      int held_slot[USERS_MAX];
      int hold_cnt[USERS_MAX];
      slot_result_type expected_q[$];
      int fail_count;
      int frames_seen;
      int results_seen;

      function new();
         users_cfg = RESET_USERS_IN_USE;
         limit_cfg = RESET_HOLD_LIMIT;
         foreach (held_slot[i]) begin
            held_slot[i] = 0;
            hold_cnt[i]  = 0;
         end
         fail_count   = 0;
         frames_seen  = 0;
         results_seen = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_USERS_IN_USE: begin
               users_cfg = value;
            end
            CSR_HOLD_LIMIT: begin
               limit_cfg = value;
            end
            default: begin
            end
         endcase
      endfunction

      // Slots at or above the slot count are never available.
      function int slot_bit(int slot);
         return (slot < SLOTS) ? (1 << slot) : 0;
      endfunction

      // Runs both assignment passes for one frame and queues one result per user in use.
      function void note_frame(logic [MASK_W-1:0] mask);
         int n;
         int lim;
         int tracked;
         int avail;
         int c;
         int b;
         int slot;
         bit held;
         slot_result_type r;
         n = users_cfg;
         if (n == 0) n = 1;
         if (n > USERS_MAX) n = USERS_MAX;
         lim = limit_cfg;
         if (lim == 0) lim = 1;
         tracked = int'(mask) & ((1 << SLOTS) - 1);
         avail = tracked;
         frames_seen++;

         // Renewal pass: held slots that are still tracked and unclaimed.
         for (int i = 0; i < n; i++) begin
            if (hold_cnt[i] != 0) begin
               b = slot_bit(held_slot[i]);
               if ((avail & b) != 0) begin
                  avail &= ~b;
                  c = hold_cnt[i] + 1;
                  if (c > lim) c = lim;
                  hold_cnt[i] = c & 7;
               end else begin
                  hold_cnt[i] = (hold_cnt[i] - 1) & 7;
               end
            end
         end

         // Hand-out pass: free users take the lowest available slot.
         for (int i = 0; i < n; i++) begin
            if (hold_cnt[i] == 0) begin
               for (int j = 0; j < SLOTS; j++) begin
                  b = slot_bit(j);
                  if ((avail & b) != 0) begin
                     held_slot[i] = j & 7;
                     hold_cnt[i]  = 1;
                     avail &= ~b;
                     break;
                  end
               end
            end
         end

         for (int i = 0; i < n; i++) begin
            held = (hold_cnt[i] != 0);
            slot = held ? held_slot[i] : 0;
            r.user_index = i[USER_W-1:0];
            r.slot_id    = slot[SLOT_W-1:0];
            r.hold_count = hold_cnt[i][CNT_W-1:0];
            r.track_id   = (held && (tracked & slot_bit(slot)) != 0) ? SLOT_W'(slot + 1) : '0;
            r.last       = (i + 1 == n);
            expected_q.insert(expected_q.size(), r);
         end
      endfunction

      function void check_field(string name, int expv, int actv);
         if (expv != actv) begin
            fail_count++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, expv, actv);
         end
      endfunction

      function void check_result(slot_result_type got);
         slot_result_type want;
         results_seen++;
         if (expected_q.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result, expected none, actual user %0d slot %0d count %0d",
                     $time, got.user_index, got.slot_id, got.hold_count);
         end else begin
            want = expected_q.pop_front();
            check_field("user_index", want.user_index, got.user_index);
            check_field("slot_id", want.slot_id, got.slot_id);
            check_field("hold_count", want.hold_count, got.hold_count);
            check_field("track_id", want.track_id, got.track_id);
            check_field("last", want.last, got.last);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [MASK_W-1:0]     req_tracked_mask = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [USER_W-1:0]     rsp_user_index;
   logic [SLOT_W-1:0]     rsp_slot_id;
   logic [CNT_W-1:0]      rsp_hold_count;
   logic [SLOT_W-1:0]     rsp_track_id;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   slot_board_type        board;
   slot_result_type       seen_result;
   logic [MASK_W-1:0]     last_mask = '0;
   logic                  hold_off = 1'b0;
   int                    send_idle_pct = 0;
   int                    recv_stall_pct = 0;
   int                    phase_no = 0;

   tracked_target_slot_assigner dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_tracked_mask (req_tracked_mask),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_user_index   (rsp_user_index),
      .rsp_slot_id      (rsp_slot_id),
      .rsp_hold_count   (rsp_hold_count),
      .rsp_track_id     (rsp_track_id),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Clock generation.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result monitor and receiver stall generation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_result.user_index = rsp_user_index;
         seen_result.slot_id    = rsp_slot_id;
         seen_result.hold_count = rsp_hold_count;
         seen_result.track_id   = rsp_track_id;
         seen_result.last       = rsp_last;
         board.check_result(seen_result);
      end
      rsp_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
   end

   // Long receiver hold-off at the start of the last phase, so that the block backs up.
   initial begin
      wait (phase_no == 3);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_LEN) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Offers one frame item, after random idle cycles, and notes it once accepted.
   task automatic send_frame(input logic [MASK_W-1:0] mask);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_tracked_mask <= mask;
      do @(posedge clock); while (req_stall);
      board.note_frame(mask);
      last_mask = mask;
   endtask

   // Waits until every expected result has left and the block has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] users,
                             input logic [CSR_DATA_W-1:0] limit);
      settle();
      write_csr(CSR_USERS_IN_USE, users);
      write_csr(CSR_HOLD_LIMIT, limit);
   endtask

   // Mostly slowly drifting masks, so that counters climb and slots persist; some noise.
   task automatic random_frames(input int count);
      logic [MASK_W-1:0] mask;
      for (int k = 0; k < count; k++) begin
         mask = last_mask;
         if ($urandom_range(99) < 80) begin
            for (int j = 0; j < MASK_W; j++) begin
               if ($urandom_range(7) == 0) mask[j] = ~mask[j];
            end
         end else begin
            mask = MASK_W'($urandom);
         end
         send_frame(mask);
      end
   endtask

   // Main sequence.
   initial begin
      int guard;
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: empty, full, single slots at both ends, decay and a sparse mask.
      send_frame(6'd0);
      send_frame(6'd63);
      send_frame(6'd63);
      send_frame(6'd1);
      send_frame(6'd32);
      send_frame(6'd0);
      send_frame(6'd0);
      send_frame(6'b101010);

      // All users, top limit: counters climb to saturation.
      set_config(3'd4, 3'd7);
      repeat (7) send_frame(6'd63);
      // Lowered limit: a counter above it is clipped on claim, and decrements otherwise.
      settle();
      write_csr(CSR_HOLD_LIMIT, 3'd2);
      send_frame(6'd63);
      send_frame(6'b000011);

      // Zero users and zero limit both act as one.
      set_config(3'd0, 3'd0);
      send_frame(6'd63);
      send_frame(6'd0);

      // Too many users acts as the full count.
      set_config(3'd7, 3'd3);
      send_frame(6'b010101);
      send_frame(6'd63);

      // Users dropped out of use keep their state until taken back.
      settle();
      write_csr(CSR_USERS_IN_USE, 3'd1);
      send_frame(6'd0);
      settle();
      write_csr(CSR_USERS_IN_USE, 3'd4);
      send_frame(6'd63);

      // Random phase one: sender idles lightly, receiver heavily.
      set_config(3'd4, 3'd7);
      phase_no       = 1;
      send_idle_pct  = 31;
      recv_stall_pct = 78;
      random_frames(16);
      set_config(3'($urandom), 3'($urandom));
      random_frames(16);

      // Random phase two: the other way round.
      set_config(3'd1, 3'd1);
      phase_no       = 2;
      send_idle_pct  = 78;
      recv_stall_pct = 31;
      random_frames(16);
      set_config(3'($urandom), 3'($urandom));
      random_frames(16);

      // Random phase three: no idling, with one long receiver hold-off.
      set_config(3'd7, 3'd0);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      phase_no       = 3;
      random_frames(16);
      set_config(3'($urandom), 3'($urandom));
      random_frames(16);

      // Drain and final verdict.
      req_valid <= 1'b0;
      guard = 0;
      while (board.pending() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending() != 0) begin
         board.fail_count++;
         $display("%0t: %0d expected results never arrived", $time, board.pending());
      end
      $display("Run covered %0d frames and %0d user results over many register settings,",
               board.frames_seen, board.results_seen);
      $display("with idling on both sides, a long receiver hold-off and the special settings.");
      if (board.fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog for a hung run.
   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/tsa_pkg.sv
rtl/core/tsa_cell.sv
rtl/core/tracked_target_slot_assigner.sv
dv/tb.sv
